### src/i2cm_pkg.sv
`default_nettype none
package i2cm_pkg;

  localparam int unsigned CfgW      = 8;
  localparam int unsigned TdataInW  = 16;
  localparam int unsigned TdataOutW = 16;
  localparam int unsigned TuserInW  = 3;
  localparam logic [CfgW-1:0] HALF_PERIOD_RST = 8'd20;

  typedef enum logic [2:0] {
    OP_NONE     = 3'd0,
    OP_START    = 3'd1,
    OP_STOP     = 3'd2,
    OP_WRITE    = 3'd3,
    OP_WAIT_ACK = 3'd4,
    OP_READ     = 3'd5
  } op_t;

  // one tick of input
  typedef struct packed {
    logic       sda_in;
    logic       ack_to_send;
    logic [7:0] write_data;
    logic [2:0] operation;
  } item_t;

  // one tick of result, scl_level in bit 0
  typedef struct packed {
    logic       ack_received;
    logic [7:0] read_data;
    logic       done_res;
    logic       busy_res;
    logic       sda_drive;
    logic       sda_level;
    logic       scl_level;
  } res_t;

  localparam int unsigned ResW = $bits(res_t);

endpackage
`default_nettype wire

### src/i2c_bit_level_master.sv
`default_nettype none
// channel   direction  payload
// in_       slave      tuser: operation; tdata: write_data, ack_to_send, sda_in
// out_      master     tdata: line levels, busy, done, read_data, ack_received
// cfg_      slave      data: half_period
// one item per cycle sustained while out_tready is high; an input passes the
// input register, then the result register loaded by the sequencer step
// a full result register with out_tready low stops the sequencer and fills the
// input register, after which in_tready drops
// rst_n is synchronous: lines return to scl high, sda high and driven
// cfg_ready is always high; half_period resets to 20
module i2c_bit_level_master (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // [7:0] write_data, [8] ack_to_send, [9] sda_in, [15:10] zero
  input  wire logic [i2cm_pkg::TdataInW-1:0]  in_tdata,
  // [2:0] operation
  input  wire logic [i2cm_pkg::TuserInW-1:0]  in_tuser,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // [0] scl_level, [1] sda_level, [2] sda_drive, [3] busy_res, [4] done_res,
  // [12:5] read_data, [13] ack_received, [15:14] zero
  output logic [i2cm_pkg::TdataOutW-1:0]      out_tdata,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [i2cm_pkg::CfgW-1:0]      cfg_data
);

  logic [i2cm_pkg::CfgW-1:0] hp_r;
  i2cm_pkg::item_t           item_in, item_s1;
  i2cm_pkg::res_t            res_comb, res_out;
  logic                      s1_valid, s1_adv, in_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hp_r <= i2cm_pkg::HALF_PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      hp_r <= cfg_data;
    end
  end

  assign cfg_ready = 1'b1;

  always_comb begin
    item_in.operation   = in_tuser[2:0];
    item_in.write_data  = in_tdata[7:0];
    item_in.ack_to_send = in_tdata[8];
    item_in.sda_in      = in_tdata[9];
  end

  assign s1_adv    = s1_valid && (!out_tvalid || out_tready);
  assign in_tready = !s1_valid || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  i2cm_in_reg u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (in_acc),
    .adv      (s1_adv),
    .item_in  (item_in),
    .valid    (s1_valid),
    .item_out (item_s1)
  );

  i2cm_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (s1_adv),
    .item        (item_s1),
    .half_period (hp_r),
    .res         (res_comb)
  );

  i2cm_out_reg u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (s1_adv),
    .taken   (out_tready),
    .res_in  (res_comb),
    .valid   (out_tvalid),
    .res_out (res_out)
  );

  assign out_tdata = {{(i2cm_pkg::TdataOutW - i2cm_pkg::ResW){1'b0}}, res_out};

  // a finishing tick leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res_out.done_res |-> !res_out.busy_res)
    else $error("done reported while still busy");

  // every sequencer step lands in the result register
  a_step_lands: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_tvalid)
    else $error("sequencer step lost its result");

  // an input item never overwrites one still waiting
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid && !s1_adv |-> !in_tready)
    else $error("input register overrun");

endmodule
`default_nettype wire

### src/i2cm_in_reg.sv
`default_nettype none
module i2cm_in_reg (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            load,
  input  wire logic            adv,
  input  wire i2cm_pkg::item_t item_in,
  output logic                 valid,
  output i2cm_pkg::item_t      item_out
);

  logic            valid_r, valid_nxt;
  i2cm_pkg::item_t item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item_in;
    end
  end

  assign valid    = valid_r;
  assign item_out = item_r;

endmodule
`default_nettype wire

### src/i2cm_seq.sv
`default_nettype none
module i2cm_seq (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      step,
  input  wire i2cm_pkg::item_t           item,
  input  wire logic [i2cm_pkg::CfgW-1:0] half_period,
  output i2cm_pkg::res_t                 res
);

  typedef struct packed {
    logic scl;
    logic sda;
    logic drv;
  } lines_t;

  i2cm_pkg::op_t cmd_r, cmd_nxt;
  logic          ph_r, ph_nxt;
  logic [3:0]    bc_r, bc_nxt;
  logic [7:0]    dly_r, dly_nxt;
  logic [7:0]    sh_r, sh_nxt;
  lines_t        ln_r, ln_nxt;
  logic          ackf_r, ackf_nxt;
  logic          ackc_r, ackc_nxt;
  logic [7:0]    rd_r, rd_nxt;
  logic          done;
  logic [7:0]    dly_load;

  function automatic lines_t seg_lines(input i2cm_pkg::op_t cmd, input logic ph,
                                       input logic [3:0] bc, input logic [7:0] sh,
                                       input logic ackc, input lines_t cur);
    lines_t l;
    l = cur;
    case (cmd)
      i2cm_pkg::OP_START: begin
        l.drv = 1'b1; l.scl = 1'b1; l.sda = !ph;
      end
      i2cm_pkg::OP_STOP: begin
        l.drv = 1'b1; l.scl = 1'b1; l.sda = ph;
      end
      i2cm_pkg::OP_WRITE: begin
        l.drv = 1'b1; l.scl = ph; l.sda = sh[7];
      end
      i2cm_pkg::OP_WAIT_ACK: begin
        l.drv = 1'b0; l.scl = !ph;
      end
      i2cm_pkg::OP_READ: begin
        if (bc < 4'd8) begin
          l.drv = 1'b0;
        end else begin
          l.drv = 1'b1;
          l.sda = !ackc;
        end
        l.scl = ph;
      end
      default: ;
    endcase
    return l;
  endfunction

  function automatic logic [3:0] bits_of(input i2cm_pkg::op_t cmd);
    logic [3:0] n;
    case (cmd)
      i2cm_pkg::OP_WRITE: n = 4'd8;
      i2cm_pkg::OP_READ:  n = 4'd9;
      default:            n = 4'd1;
    endcase
    return n;
  endfunction

  // a half period of zero behaves as one
  assign dly_load = (half_period == '0) ? 8'd0 : half_period - 8'd1;

  always_comb begin
    cmd_nxt  = cmd_r;
    ph_nxt   = ph_r;
    bc_nxt   = bc_r;
    dly_nxt  = dly_r;
    sh_nxt   = sh_r;
    ln_nxt   = ln_r;
    ackf_nxt = ackf_r;
    ackc_nxt = ackc_r;
    rd_nxt   = rd_r;
    done     = 1'b0;
    if (cmd_r == i2cm_pkg::OP_NONE) begin
      if (item.operation inside {[i2cm_pkg::OP_START:i2cm_pkg::OP_READ]}) begin
        cmd_nxt = i2cm_pkg::op_t'(item.operation);
        ph_nxt  = 1'b0;
        bc_nxt  = 4'd0;
        if (cmd_nxt == i2cm_pkg::OP_WRITE) begin
          sh_nxt = item.write_data;
        end
        if (cmd_nxt == i2cm_pkg::OP_READ) begin
          sh_nxt   = 8'd0;
          ackc_nxt = item.ack_to_send;
        end
        ln_nxt  = seg_lines(cmd_nxt, 1'b0, 4'd0, sh_nxt, ackc_nxt, ln_r);
        dly_nxt = dly_load;
      end
    end else if (dly_r != 8'd0) begin
      dly_nxt = dly_r - 8'd1;
    end else begin
      if (cmd_r == i2cm_pkg::OP_WAIT_ACK && !ph_r) begin
        ackf_nxt = item.sda_in;
      end
      if (!ph_r) begin
        ph_nxt = 1'b1;
      end else begin
        ph_nxt = 1'b0;
        if (cmd_r == i2cm_pkg::OP_WRITE) begin
          sh_nxt = {sh_r[6:0], 1'b0};
        end
        bc_nxt = bc_r + 4'd1;
      end
      if (bc_nxt >= bits_of(cmd_r)) begin
        if (cmd_r == i2cm_pkg::OP_START || cmd_r == i2cm_pkg::OP_WRITE) begin
          ln_nxt.scl = 1'b0;
        end
        if (cmd_r == i2cm_pkg::OP_READ) begin
          ln_nxt.scl = 1'b0;
          rd_nxt     = sh_nxt;
        end
        cmd_nxt = i2cm_pkg::OP_NONE;
        ph_nxt  = 1'b0;
        bc_nxt  = 4'd0;
        done    = 1'b1;
      end else begin
        ln_nxt = seg_lines(cmd_r, ph_nxt, bc_nxt, sh_nxt, ackc_r, ln_r);
        // data bit sampled as scl goes high
        if (cmd_r == i2cm_pkg::OP_READ && ph_nxt && bc_nxt < 4'd8) begin
          sh_nxt = {sh_nxt[6:0], item.sda_in};
        end
        dly_nxt = dly_load;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r  <= i2cm_pkg::OP_NONE;
      ph_r   <= 1'b0;
      bc_r   <= 4'd0;
      dly_r  <= 8'd0;
      sh_r   <= 8'd0;
      ln_r   <= '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
      ackf_r <= 1'b0;
      ackc_r <= 1'b0;
      rd_r   <= 8'd0;
    end else if (step) begin
      cmd_r  <= cmd_nxt;
      ph_r   <= ph_nxt;
      bc_r   <= bc_nxt;
      dly_r  <= dly_nxt;
      sh_r   <= sh_nxt;
      ln_r   <= ln_nxt;
      ackf_r <= ackf_nxt;
      ackc_r <= ackc_nxt;
      rd_r   <= rd_nxt;
    end
  end

  always_comb begin
    res.scl_level    = ln_nxt.scl;
    res.sda_level    = ln_nxt.sda;
    res.sda_drive    = ln_nxt.drv;
    res.busy_res     = (cmd_nxt != i2cm_pkg::OP_NONE);
    res.done_res     = done;
    res.read_data    = rd_nxt;
    res.ack_received = ackf_nxt;
  end

endmodule
`default_nettype wire

### src/i2cm_out_reg.sv
`default_nettype none
module i2cm_out_reg (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           load,
  input  wire logic           taken,
  input  wire i2cm_pkg::res_t res_in,
  output logic                valid,
  output i2cm_pkg::res_t      res_out
);

  logic           valid_r, valid_nxt;
  i2cm_pkg::res_t res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (taken) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign valid   = valid_r;
  assign res_out = res_r;

endmodule
`default_nettype wire
